[sv/lska_pkg.sv]
// Shared types, constants and helpers for the latency sample aggregator.
package lska_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CELL_W = 4;
	localparam int CELLS = 1 << CELL_W;
	localparam int HIST_AW = IDX_W + CELL_W;
	localparam int SLOT_W = 6;
	localparam int IN_W = 312;
	localparam int OUT_W = 176;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam logic [7:0] SRC_CODE_L1 = 8'd0;
	localparam logic [7:0] SRC_CODE_L2 = 8'd8;
	localparam logic [7:0] SRC_CODE_PEER_CLUSTER = 8'd9;
	localparam logic [7:0] SRC_CODE_LOCAL_CLUSTER = 8'd10;
	localparam logic [7:0] SRC_CODE_SYSTEM_CACHE = 8'd11;

	localparam logic [CFG_AW-1:0] REG_CYC2PS = 3'd0;
	localparam logic [CFG_AW-1:0] REG_CAP1 = 3'd1;
	localparam logic [CFG_AW-1:0] REG_CAP2 = 3'd2;
	localparam logic [CFG_AW-1:0] REG_CAP3 = 3'd3;
	localparam logic [CFG_AW-1:0] REG_SATCODE = 3'd4;

	typedef enum logic [1:0] {
		GRP_L1 = 2'd0,
		GRP_L2 = 2'd1,
		GRP_L3 = 2'd2,
		GRP_MEM = 2'd3
	} lska_group_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ALLOC,
		ST_CALC,
		ST_EXEC,
		ST_BIN,
		ST_HREAD,
		ST_UPDATE
	} lska_state_t;

	typedef struct packed {
		logic accept;
		logic search;
		logic alloc;
		logic calc;
		logic exec;
		logic bin;
		logic hread;
		logic update;
	} lska_cmd_t;

	typedef struct packed {
		logic srch_done;
		logic hit;
		logic free_ok;
		logic clr_last;
		logic out_full;
	} lska_stat_t;

	typedef struct packed {
		logic [63:0] inode;
		logic [31:0] major;
		logic [31:0] minor;
		logic [63:0] gen;
		logic [63:0] offset;
		logic [63:0] sum_tot;
		logic [63:0] sum_iss;
		logic [63:0] sum_xl;
		logic [31:0] cnt_samples;
		logic [31:0] cnt_sat;
	} lska_entry_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic lska_group_t group_of(input logic [7:0] code);
		lska_group_t g;
		if (code == SRC_CODE_L1) g = GRP_L1;
		else if (code == SRC_CODE_L2) g = GRP_L2;
		else if (code == SRC_CODE_PEER_CLUSTER || code == SRC_CODE_LOCAL_CLUSTER ||
			code == SRC_CODE_SYSTEM_CACHE) g = GRP_L3;
		else g = GRP_MEM;
		return g;
	endfunction

endpackage

[sv/lska_ctrl.sv]
// Sequencer: walks each request through search, allocation, arithmetic and update.
module lska_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  lska_pkg::lska_stat_t stat,
	output lska_pkg::lska_cmd_t  cmd
);
	import lska_pkg::*;

	lska_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.srch_done) begin
					if (stat.hit) state_d = ST_CALC;
					else if (stat.free_ok) state_d = ST_ALLOC;
					else state_d = ST_UPDATE;
				end
			end
			ST_ALLOC: begin
				cmd.alloc = 1'b1;
				if (stat.clr_last) state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = ST_BIN;
			end
			ST_BIN: begin
				cmd.bin = 1'b1;
				state_d = ST_HREAD;
			end
			ST_HREAD: begin
				cmd.hread = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				if (!stat.out_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[sv/lska_dp.sv]
// Datapath: config registers, entry and histogram memories, arithmetic, result register.
module lska_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lska_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [lska_pkg::CFG_DW-1:0]    cfg_data,
	input  logic [lska_pkg::IN_W-1:0]      s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lska_pkg::OUT_W-1:0]     m_tdata,
	input  lska_pkg::lska_cmd_t            cmd,
	output lska_pkg::lska_stat_t           stat
);
	import lska_pkg::*;

	// config
	logic [15:0] cyc2ps_q, satcode_q;
	logic [31:0] cap1_q, cap2_q, cap3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc2ps_q <= 16'd1000;
			cap1_q <= 32'd4000;
			cap2_q <= 32'd15000;
			cap3_q <= 32'd50000;
			satcode_q <= 16'd4095;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CYC2PS: cyc2ps_q <= cfg_data[15:0];
				REG_CAP1: cap1_q <= cfg_data;
				REG_CAP2: cap2_q <= cfg_data;
				REG_CAP3: cap3_q <= cfg_data;
				REG_SATCODE: satcode_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// captured request
	logic [63:0] inode_q, gen_q, off_q;
	logic [31:0] maj_q, min_q;
	logic [15:0] tot_q, iss_q, xl_q;
	logic sat_q;
	lska_group_t grp_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			inode_q <= s_tdata[63:0];
			maj_q <= s_tdata[95:64];
			min_q <= s_tdata[127:96];
			gen_q <= s_tdata[191:128];
			off_q <= s_tdata[255:192];
			tot_q <= s_tdata[271:256];
			iss_q <= s_tdata[287:272];
			xl_q <= s_tdata[303:288];
			sat_q <= (s_tdata[287:272] == satcode_q);
			grp_q <= group_of(s_tdata[311:304]);
		end
	end

	// entry memory, one read and one write port
	lska_entry_t ent_mem [TABLE_ENTRIES];
	lska_entry_t ent_rd_q, ent_wdata;
	logic [IDX_W-1:0] ent_raddr;
	logic ent_we;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IDX_W:0] cnt_q;
	logic [IDX_W-1:0] idx_s1, slot_q, free_idx_q, slot_sel;
	logic pend_s1, hit_q, free_ok_q, issue, key_eq;
	logic [CELL_W-1:0] clr_q;

	assign slot_sel = hit_q ? slot_q : free_idx_q;
	assign issue = cmd.search && !cnt_q[IDX_W] && !hit_q;
	assign ent_raddr = issue ? cnt_q[IDX_W-1:0] : slot_sel;
	assign key_eq = ent_rd_q.inode == inode_q && ent_rd_q.offset == off_q &&
		ent_rd_q.major == maj_q && ent_rd_q.minor == min_q && ent_rd_q.gen == gen_q;

	always_ff @(posedge clk) begin
		ent_rd_q <= ent_mem[ent_raddr];
		if (ent_we) ent_mem[slot_sel] <= ent_wdata;
	end

	// key search walk, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_ok_q <= 1'b0;
			clr_q <= '0;
		end else begin
			if (cmd.accept) begin
				cnt_q <= '0;
				pend_s1 <= 1'b0;
				hit_q <= 1'b0;
				free_ok_q <= 1'b0;
				clr_q <= '0;
			end else begin
				pend_s1 <= issue;
				if (issue) cnt_q <= cnt_q + 1'b1;
				if (pend_s1 && !hit_q) begin
					if (valid_q[idx_s1] && key_eq) hit_q <= 1'b1;
					if (!valid_q[idx_s1] && !free_ok_q) free_ok_q <= 1'b1;
				end
				if (cmd.alloc) begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CELL_W'(CELLS - 1)) valid_q[free_idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (pend_s1 && !hit_q) begin
			if (valid_q[idx_s1] && key_eq) slot_q <= idx_s1;
			if (!valid_q[idx_s1] && !free_ok_q) free_idx_q <= idx_s1;
		end
	end

	// arithmetic
	logic [31:0] tps_s1, ips_s1, xps_s1;
	logic [63:0] exec_s2;
	logic [1:0] bin_q;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			tps_s1 <= tot_q * cyc2ps_q;
			ips_s1 <= iss_q * cyc2ps_q;
			xps_s1 <= xl_q * cyc2ps_q;
		end
		if (cmd.exec) exec_s2 <= {32'd0, tps_s1} - {32'd0, ips_s1} - {32'd0, xps_s1};
		if (cmd.bin) begin
			if (exec_s2 <= {32'd0, cap1_q}) bin_q <= 2'd0;
			else if (exec_s2 <= {32'd0, cap2_q}) bin_q <= 2'd1;
			else if (exec_s2 <= {32'd0, cap3_q}) bin_q <= 2'd2;
			else bin_q <= 2'd3;
		end
	end

	// histogram memory
	logic [31:0] hist_mem [1 << HIST_AW];
	logic [31:0] hist_rd_q, hist_wdata, hist_n;
	logic [HIST_AW-1:0] hist_addr;
	logic hist_we, upd_go, full;

	assign full = !hit_q && !free_ok_q;
	assign upd_go = cmd.update && !stat.out_full;
	assign hist_addr = cmd.alloc ? {slot_sel, clr_q} : {slot_sel, grp_q, bin_q};
	assign hist_n = sat_inc(hist_rd_q);
	assign hist_we = cmd.alloc || (upd_go && !full && !sat_q);
	assign hist_wdata = cmd.alloc ? 32'd0 : hist_n;

	always_ff @(posedge clk) begin
		if (cmd.hread) hist_rd_q <= hist_mem[hist_addr];
		if (hist_we) hist_mem[hist_addr] <= hist_wdata;
	end

	// entry update
	lska_entry_t ent_n;
	always_comb begin
		ent_n = ent_rd_q;
		ent_n.cnt_samples = sat_inc(ent_rd_q.cnt_samples);
		if (sat_q) begin
			ent_n.cnt_sat = sat_inc(ent_rd_q.cnt_sat);
		end else begin
			ent_n.sum_tot = ent_rd_q.sum_tot + {32'd0, tps_s1};
			ent_n.sum_iss = ent_rd_q.sum_iss + {32'd0, ips_s1};
			ent_n.sum_xl = ent_rd_q.sum_xl + {32'd0, xps_s1};
		end
		if (cmd.alloc) begin
			ent_wdata = '0;
			ent_wdata.inode = inode_q;
			ent_wdata.major = maj_q;
			ent_wdata.minor = min_q;
			ent_wdata.gen = gen_q;
			ent_wdata.offset = off_q;
		end else begin
			ent_wdata = ent_n;
		end
	end
	assign ent_we = (cmd.alloc && clr_q == '0) || (upd_go && !full);

	// result register
	logic m_tvalid_q;
	logic [OUT_W-1:0] res_q, res_d;

	always_comb begin
		res_d = '0;
		res_d[8] = sat_q;
		if (full) begin
			res_d[7] = 1'b1;
		end else begin
			res_d[5:0] = SLOT_W'(slot_sel);
			res_d[6] = !hit_q;
			res_d[40:9] = ent_n.cnt_samples;
			res_d[72:41] = ent_n.cnt_sat;
			res_d[136:73] = ent_n.sum_tot;
			if (!sat_q) begin
				res_d[138:137] = grp_q;
				res_d[140:139] = bin_q;
				res_d[172:141] = hist_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (upd_go) m_tvalid_q <= 1'b1;
		else if (m_tready) m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (upd_go) res_q <= res_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = res_q;

	assign stat.srch_done = hit_q || (cnt_q[IDX_W] && !pend_s1);
	assign stat.hit = hit_q;
	assign stat.free_ok = free_ok_q;
	assign stat.clr_last = clr_q == CELL_W'(CELLS - 1);
	assign stat.out_full = m_tvalid_q && !m_tready;

`ifndef NO_ASSERTIONS
	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search |-> !ent_we && !hist_we)
		else $error("memory write during key search");
	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> valid_q[slot_q])
		else $error("hit on an invalid entry");
	a_alloc_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc && stat.clr_last |=> valid_q[$past(free_idx_q)])
		else $error("allocated entry not marked valid");
`endif

endmodule

[sv/latency_sample_keyed_aggregator_top.sv]
// Top level of the latency sample aggregator: sequencer plus datapath.
//
// Usage:
//  s_* carries one profiling sample per request (key, three latencies, source).
//  m_* returns one result per sample: slot, flags, updated counts, the entry's
//  total picosecond sum, source group, latency bin and updated bin counter.
//  cfg_we/cfg_addr/cfg_data write the five setup registers; write only while idle.
// Sequence: the key search walks the 64-entry table through the entry memory's
//  single read port, one entry a cycle, and ends once a hit is registered or the
//  whole table is walked. A new key then zeroes the 16 cells of its histogram
//  row. After that come multiply, subtract, bin compare, histogram read and the
//  update, in that order. The result is registered in the update step; a hit
//  skips the zeroing, and a full table goes straight from the walk to the update
//  and drops the sample. The next request is taken in the cycle after that.
//  One sample is in work at a time; s_tready is high only between samples.
// Stall: the result sits in an output register; a new sample is taken while it
//  waits, and the update stage holds until the register frees up.
// Reset: arst_n clears all valid marks and config to defaults; the table is then
//  empty and no clearing pass is needed.
module latency_sample_keyed_aggregator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lska_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [lska_pkg::CFG_DW-1:0]    cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// inode_number, device_major, device_minor, inode_generation, file_offset,
	// total_cycles, issue_cycles, translation_cycles, source_code
	input  logic [lska_pkg::IN_W-1:0]      s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// slot_index, was_new, table_full, sample_was_saturated, entry_samples,
	// entry_saturated, entry_total_ps, source_group, latency_bin, bin_value, pad
	output logic [lska_pkg::OUT_W-1:0]     m_tdata
);
	import lska_pkg::*;

	lska_cmd_t cmd;
	lska_stat_t stat;

	lska_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	lska_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cmd(cmd),
		.stat(stat)
	);

endmodule

[tb/testbench.sv]
// Self-checking testbench for the keyed latency sample aggregator.
//
// Samples go in on the s_* stream, results come back on m_*. A predictor in
// this file keeps its own copy of the table (keys, counts, total sum and the
// sixteen bin counters per entry) and works out each result when its request
// is accepted. A checker process pops the oldest expectation per result and
// compares every field.
//
// Tests, in order:
//  directed   - default setup: fresh key, hits, saturated sample, every source
//               group, every latency bin, negative execution latency, extreme
//               key and latency values
//  extremes   - largest and smallest factor, caps and saturation code, plus a
//               write to an unused register index that must change nothing
//  random     - several phases with random setups. Keys come mostly from a pool
//               of keys already seen, so the table is hit often, fills up and
//               then drops new keys. One phase has a long receiver hold-off;
//               every phase ends with a sender pause until all results are back.
module testbench;
	import lska_pkg::*;

	localparam int LIMIT = 2_000_000;
	localparam int SETTLE = 120;          // > worst-case request latency
	localparam int LONG_HOLD = 400;
	localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [63:0] inode;
		logic [31:0] major;
		logic [31:0] minor;
		logic [63:0] gen;
		logic [63:0] offset;
		logic [15:0] total;
		logic [15:0] issue;
		logic [15:0] xlat;
		logic [7:0]  src;
	} sample_t;

	typedef struct {
		logic [5:0]  slot;
		logic        fresh;
		logic        full;
		logic        sat;
		logic [31:0] samples;
		logic [31:0] saturated;
		logic [63:0] total_ps;
		logic [1:0]  group;
		logic [1:0]  bin;
		logic [31:0] bin_value;
	} result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	latency_sample_keyed_aggregator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// predictor copy of setup and table
	logic [15:0] scale_ps;
	logic [31:0] cap1, cap2, cap3;
	logic [15:0] sat_code;
	logic        ent_valid [TABLE_ENTRIES];
	sample_t     ent_key [TABLE_ENTRIES];
	logic [31:0] ent_samples [TABLE_ENTRIES];
	logic [31:0] ent_saturated [TABLE_ENTRIES];
	logic [63:0] ent_total_ps [TABLE_ENTRIES];
	logic [31:0] ent_bins [TABLE_ENTRIES][16];

	result_t pending_results[$];
	sample_t key_pool[$];
	int      errors;
	int      cycles;
	bit      tx_idle;            // sender gaps on/off
	bit      rx_idle;            // receiver stalls on/off
	bit      hold_request;       // asks the receiver for one long hold-off

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic lska_group_t source_group(logic [7:0] code);
		if (code == SRC_CODE_L1)
			return GRP_L1;
		if (code == SRC_CODE_L2)
			return GRP_L2;
		if (code == SRC_CODE_PEER_CLUSTER || code == SRC_CODE_LOCAL_CLUSTER ||
				code == SRC_CODE_SYSTEM_CACHE)
			return GRP_L3;
		return GRP_MEM;
	endfunction

	function automatic logic [31:0] bump(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Folds one sample into the predicted table and returns the result it causes.
	function automatic result_t aggregate_sample(sample_t s);
		result_t r;
		int hit, free_ent;
		logic [63:0] tps, ips, xps, exec_ps;
		logic [3:0] hist_cell;
		hit = -1;
		free_ent = -1;
		r = '{default: '0};
		r.group = GRP_L1;
		r.sat = (s.issue == sat_code);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (ent_valid[i]) begin
				if (hit < 0 && ent_key[i].inode == s.inode && ent_key[i].major == s.major &&
						ent_key[i].minor == s.minor && ent_key[i].gen == s.gen &&
						ent_key[i].offset == s.offset)
					hit = i;
			end else if (free_ent < 0) begin
				free_ent = i;
			end
		end
		if (hit < 0) begin
			if (free_ent < 0) begin
				r.full = 1'b1;
				return r;
			end
			hit = free_ent;
			r.fresh = 1'b1;
			ent_valid[hit] = 1'b1;
			ent_key[hit] = s;
			ent_samples[hit] = '0;
			ent_saturated[hit] = '0;
			ent_total_ps[hit] = '0;
			for (int c = 0; c < 16; c++)
				ent_bins[hit][c] = '0;
		end
		ent_samples[hit] = bump(ent_samples[hit]);
		if (r.sat) begin
			ent_saturated[hit] = bump(ent_saturated[hit]);
		end else begin
			tps = 64'(s.total) * 64'(scale_ps);
			ips = 64'(s.issue) * 64'(scale_ps);
			xps = 64'(s.xlat) * 64'(scale_ps);
			ent_total_ps[hit] = ent_total_ps[hit] + tps;
			exec_ps = tps - ips - xps;      // wraps when issue + translation > total
			r.group = source_group(s.src);
			if (exec_ps <= 64'(cap1))
				r.bin = 2'd0;
			else if (exec_ps <= 64'(cap2))
				r.bin = 2'd1;
			else if (exec_ps <= 64'(cap3))
				r.bin = 2'd2;
			else
				r.bin = 2'd3;
			hist_cell = {r.group, r.bin};
			ent_bins[hit][hist_cell] = bump(ent_bins[hit][hist_cell]);
			r.bin_value = ent_bins[hit][hist_cell];
		end
		r.slot = hit[5:0];
		r.samples = ent_samples[hit];
		r.saturated = ent_saturated[hit];
		r.total_ps = ent_total_ps[hit];
		return r;
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, field, got, want);
		errors++;
	endtask

	// Sends one sample; the prediction is made at the accepting edge.
	task automatic send_sample(sample_t s);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {s.src, s.xlat, s.issue, s.total, s.offset, s.gen, s.minor, s.major,
			s.inode};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(aggregate_sample(s));
	endtask

	// Writes all five setup registers back to back, then one unused index.
	task automatic write_setup(logic [15:0] scale, logic [31:0] c1, logic [31:0] c2,
			logic [31:0] c3, logic [15:0] satc);
		logic [CFG_DW-1:0] vals [5];
		logic [CFG_AW-1:0] idx [5];
		vals = '{32'(scale), c1, c2, c3, 32'(satc)};
		idx = '{REG_CYC2PS, REG_CAP1, REG_CAP2, REG_CAP3, REG_SATCODE};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_addr <= REG_UNUSED;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_ps = scale;
		cap1 = c1;
		cap2 = c2;
		cap3 = c3;
		sat_code = satc;
	endtask

	// Drops s_tvalid, waits until every result is back, then lets the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic sample_t make_sample(sample_t key, logic [15:0] tot, logic [15:0] iss,
			logic [15:0] xl, logic [7:0] src);
		sample_t s;
		s = key;
		s.total = tot;
		s.issue = iss;
		s.xlat = xl;
		s.src = src;
		return s;
	endfunction

	function automatic sample_t random_key();
		sample_t k;
		k = '{default: '0};
		k.inode = rand64();
		k.major = $urandom;
		k.minor = $urandom;
		k.gen = rand64();
		k.offset = rand64();
		return k;
	endfunction

	task automatic test_directed();
		sample_t ka, kz, ko;
		ka = random_key();
		kz = '{default: '0};
		ko = '{default: '1};
		tx_idle = 0;
		rx_idle = 0;
		// defaults: 1000 ps/cycle, caps 4000/15000/50000, saturation code 4095
		send_sample(make_sample(ka, 16'd3, 16'd1, 16'd1, SRC_CODE_L1));        // fresh, bin 0
		send_sample(make_sample(ka, 16'd12, 16'd1, 16'd1, SRC_CODE_L2));       // hit, bin 1
		send_sample(make_sample(ka, 16'd40, 16'd2, 16'd3, SRC_CODE_PEER_CLUSTER));
		send_sample(make_sample(ka, 16'd900, 16'd2, 16'd3, SRC_CODE_LOCAL_CLUSTER));
		send_sample(make_sample(ka, 16'd5, 16'd4095, 16'd1, SRC_CODE_SYSTEM_CACHE)); // saturated
		send_sample(make_sample(ka, 16'd2, 16'd9, 16'd1, 8'hFF));              // negative exec
		send_sample(make_sample(ka, 16'd4, 16'd0, 16'd0, 8'd4));               // cap1 edge
		send_sample(make_sample(ka, 16'd15, 16'd0, 16'd0, 8'd255));            // cap2 edge
		send_sample(make_sample(ka, 16'd50, 16'd0, 16'd0, SRC_CODE_L1));       // cap3 edge
		send_sample(make_sample(kz, 16'd0, 16'd0, 16'd0, 8'd0));               // all-zero key
		send_sample(make_sample(ko, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));     // all-one key
		send_sample(make_sample(ko, 16'hFFFF, 16'd0, 16'd0, 8'hAA));
		send_sample(make_sample(kz, 16'hFFFF, 16'h0FFF, 16'h0FFF, 8'h55));
		ka.offset = ka.offset ^ 64'd1;                                         // near miss
		send_sample(make_sample(ka, 16'd7, 16'd1, 16'd2, SRC_CODE_L2));
		tx_idle = 1;
		rx_idle = 1;
		for (int i = 0; i < 6; i++)
			send_sample(make_sample(ka, 16'($urandom), 16'($urandom_range(0, 20)),
				16'($urandom_range(0, 20)), 8'($urandom_range(0, 12))));
		drain();
	endtask

	task automatic test_extremes();
		sample_t k;
		k = random_key();
		write_setup(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_sample(make_sample(k, 16'hFFFF, 16'd0, 16'd0, SRC_CODE_L1));
		send_sample(make_sample(k, 16'hFFFF, 16'hFFFF, 16'd0, SRC_CODE_L2));   // saturated
		send_sample(make_sample(k, 16'd0, 16'hFFFE, 16'hFFFF, 8'd200));        // wraps, bin 3
		send_sample(make_sample(k, 16'hFFFF, 16'h8000, 16'h7FFF, SRC_CODE_SYSTEM_CACHE));
		drain();
		write_setup(16'd0, 32'd0, 32'd0, 32'd0, 16'd0);
		send_sample(make_sample(k, 16'hFFFF, 16'd0, 16'd0, SRC_CODE_L1));      // saturated
		send_sample(make_sample(k, 16'hFFFF, 16'd1, 16'hFFFF, SRC_CODE_L2));   // zero ps
		drain();
		write_setup(16'd1, 32'd10, 32'd100, 32'd1000, 16'd4095);
		send_sample(make_sample(k, 16'd1200, 16'd100, 16'd50, SRC_CODE_PEER_CLUSTER));
		send_sample(make_sample(k, 16'd60, 16'd5, 16'd5, 8'd12));
		drain();
	endtask

	// One random phase: new setup, then n samples keyed mostly from the pool.
	task automatic random_phase(int n, bit long_hold, bit pause_at_end);
		logic [15:0] scale;
		logic [31:0] c1, c2, c3;
		sample_t k;
		scale = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
		c1 = 32'(scale) * $urandom_range(0, 2000);
		c2 = c1 + 32'(scale) * $urandom_range(0, 8000);
		c3 = ($urandom_range(0, 7) == 0) ? $urandom : c2 + 32'(scale) * $urandom_range(0, 30000);
		write_setup(scale, c1, c2, c3, 16'($urandom_range(0, 4095)));
		tx_idle = 1'($urandom_range(0, 1));
		rx_idle = 1'($urandom_range(0, 1));
		for (int i = 0; i < n; i++) begin
			if (long_hold && i == n / 3) begin
				tx_idle = 0;
				hold_request = 1;
			end
			if (i == n / 2) begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
			end
			if (key_pool.size() == 0 || $urandom_range(0, 99) < 9) begin
				k = random_key();
				key_pool.push_back(k);
			end else begin
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			k.total = 16'($urandom);
			if ($urandom_range(0, 1))
				k.total = k.total >> $urandom_range(0, 14);
			k.issue = ($urandom_range(0, 7) == 0) ? sat_code : 16'(k.total >> $urandom_range(1, 6));
			if ($urandom_range(0, 15) == 0)
				k.issue = 16'($urandom);
			k.xlat = ($urandom_range(0, 15) == 0) ? 16'($urandom) :
				16'(k.total >> $urandom_range(2, 8));
			k.src = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 12)) : 8'($urandom);
			send_sample(k);
		end
		// sender pauses until every expected result is back
		if (pause_at_end)
			drain();
		drain();
	endtask

	task automatic test_random();
		random_phase(260, 1'b0, 1'b1);
		random_phase(260, 1'b1, 1'b0);
		random_phase(260, 1'b0, 1'b1);
		random_phase(260, 1'b0, 1'b0);
		random_phase(260, 1'b0, 1'b0);
	endtask

	// Result checker with random receiver stalls.
	initial begin
		int stall;
		result_t want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = rx_idle ? $urandom_range(0, 17) : 0;
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_results.size() == 0) begin
				$display("[%0t] result with no request outstanding", $realtime);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[5:0] !== want.slot)
					report("slot_index", m_tdata[5:0], want.slot);
				if (m_tdata[6] !== want.fresh)
					report("was_new", m_tdata[6], want.fresh);
				if (m_tdata[7] !== want.full)
					report("table_full", m_tdata[7], want.full);
				if (m_tdata[8] !== want.sat)
					report("sample_was_saturated", m_tdata[8], want.sat);
				if (m_tdata[40:9] !== want.samples)
					report("entry_samples", m_tdata[40:9], want.samples);
				if (m_tdata[72:41] !== want.saturated)
					report("entry_saturated", m_tdata[72:41], want.saturated);
				if (m_tdata[136:73] !== want.total_ps)
					report("entry_total_ps", m_tdata[136:73], want.total_ps);
				if (m_tdata[138:137] !== want.group)
					report("source_group", m_tdata[138:137], want.group);
				if (m_tdata[140:139] !== want.bin)
					report("latency_bin", m_tdata[140:139], want.bin);
				if (m_tdata[172:141] !== want.bin_value)
					report("bin_value", m_tdata[172:141], want.bin_value);
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		tx_idle = 0;
		rx_idle = 0;
		hold_request = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		scale_ps = 16'd1000;
		cap1 = 32'd4000;
		cap2 = 32'd15000;
		cap3 = 32'd50000;
		sat_code = 16'd4095;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			ent_valid[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_extremes();
		test_random();

		drain();
		if (errors == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
